FILE: design/sit_pkg.sv
// Shared widths, types and helpers for the segment intersection pipeline.
package sit_pkg;

	localparam int CW = 16;            // Q12.4 coordinate
	localparam int IW = CW + 1;        // endpoint, box corners need one more bit
	localparam int DW = IW + 1;        // endpoint difference
	localparam int PW = 2 * DW;        // cross product term
	localparam int SW = PW + 1;        // cross product
	localparam int MW = SW - 1;        // magnitude of a cross product
	localparam int RW = IW;            // magnitude of a segment-mode difference
	localparam int NW = MW + RW;       // dividend
	localparam int QW = RW;            // quotient bits, one per divider stage
	localparam int EDGE_LAT = 4;
	localparam int DIV_LAT = QW;
	localparam int LAT = EDGE_LAT + 1 + DIV_LAT;
	localparam int NEDGE = 4;
	localparam int OUT_W = 40;

	localparam logic CMD_SEG = 1'b0;
	localparam logic CMD_BOX = 1'b1;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [IW-1:0] ept_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] sum_t;

	typedef struct packed {
		logic  hit;
		sum_t  t;
		sum_t  d;
		diff_t rx;
		diff_t ry;
	} edge_res_t;

	// num/den within [0,1], bounds included
	function automatic logic in_unit(sum_t num, sum_t den);
		logic r;
		if (den > 0)
			r = (num >= 0) && (num <= den);
		else
			r = (num <= 0) && (num >= den);
		return r;
	endfunction

	function automatic logic [MW-1:0] mag_sum(sum_t v);
		sum_t a;
		a = (v < 0) ? -v : v;
		return a[MW-1:0];
	endfunction

	function automatic logic [RW-1:0] mag_diff(diff_t v);
		diff_t a;
		a = (v < 0) ? -v : v;
		return a[RW-1:0];
	endfunction

endpackage

FILE: design/segment_intersection_test.sv
// Segment intersection test: segment versus segment or versus box edges.
//
// Input channel s_axis: one query per transfer. s_axis_tuser is the mode
// (0 segment versus segment, 1 segment versus each edge of a box given
// as centre q0 and half size q1). s_axis_tdata holds eight signed Q12.4
// coordinates. Output channel m_axis: one result per query, in order:
// hit flag and, for a segment hit, the crossing point (else zero).
// From input transfer to output valid, a query passes four stages of
// cross products and range compares, one multiply stage, a divider that
// resolves one quotient bit per stage over 17 stages, and the output register.
// Throughput is one query per cycle while the receiver does not stall; the
// four box edges are tested by parallel units.
// Reset clears all valid bits; data registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
module segment_intersection_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// p0_x, p0_y, p1_x, p1_y, q0_x, q0_y, q1_x, q1_y (16 bits each)
	input  logic [127:0] s_axis_tdata,
	// cmd
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// hit, point_x (16), point_y (16), 7 zero bits
	output logic [sit_pkg::OUT_W-1:0] m_axis_tdata
);
	import sit_pkg::*;

	coord_t p0_x, p0_y, p1_x, p1_y, q0_x, q0_y, q1_x, q1_y;
	ept_t   lo_x, hi_x, lo_y, hi_y;
	ept_t   c_x [NEDGE];
	ept_t   c_y [NEDGE];
	ept_t   d_x [NEDGE];
	ept_t   d_y [NEDGE];
	edge_res_t res [NEDGE];

	logic          en;
	logic [LAT-1:0] vld_q;
	logic          cmd_d  [EDGE_LAT];
	coord_t        p0x_d  [EDGE_LAT];
	coord_t        p0y_d  [EDGE_LAT];
	logic          hit_s5, seg_s5;
	logic [NW-1:0] numx_s5, numy_s5;
	logic [MW-1:0] den_s5;
	logic          negx_s5, negy_s5;
	coord_t        basex_s5, basey_s5;
	logic          hit_d [DIV_LAT];
	logic          seg_d [DIV_LAT];
	coord_t        divx, divy;
	logic          out_vld_q, hit_q;
	coord_t        ptx_q, pty_q;
	logic          box_hit;

	assign p0_x = coord_t'(s_axis_tdata[15:0]);
	assign p0_y = coord_t'(s_axis_tdata[31:16]);
	assign p1_x = coord_t'(s_axis_tdata[47:32]);
	assign p1_y = coord_t'(s_axis_tdata[63:48]);
	assign q0_x = coord_t'(s_axis_tdata[79:64]);
	assign q0_y = coord_t'(s_axis_tdata[95:80]);
	assign q1_x = coord_t'(s_axis_tdata[111:96]);
	assign q1_y = coord_t'(s_axis_tdata[127:112]);

	assign lo_x = IW'(q0_x) - IW'(q1_x);
	assign hi_x = IW'(q0_x) + IW'(q1_x);
	assign lo_y = IW'(q0_y) - IW'(q1_y);
	assign hi_y = IW'(q0_y) + IW'(q1_y);

	// edge 0 doubles as the segment test; edges run bottom, right, top, left
	always_comb begin
		if (s_axis_tuser == CMD_BOX) begin
			c_x[0] = lo_x; c_y[0] = lo_y; d_x[0] = hi_x; d_y[0] = lo_y;
		end else begin
			c_x[0] = IW'(q0_x); c_y[0] = IW'(q0_y);
			d_x[0] = IW'(q1_x); d_y[0] = IW'(q1_y);
		end
		c_x[1] = hi_x; c_y[1] = lo_y; d_x[1] = hi_x; d_y[1] = hi_y;
		c_x[2] = hi_x; c_y[2] = hi_y; d_x[2] = lo_x; d_y[2] = hi_y;
		c_x[3] = lo_x; c_y[3] = hi_y; d_x[3] = lo_x; d_y[3] = lo_y;
	end

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	for (genvar e = 0; e < NEDGE; e++) begin : g_edge
		sit_edge u_edge (
			.clk (clk),
			.en  (en),
			.a_x (IW'(p0_x)),
			.a_y (IW'(p0_y)),
			.b_x (IW'(p1_x)),
			.b_y (IW'(p1_y)),
			.c_x (c_x[e]),
			.c_y (c_y[e]),
			.d_x (d_x[e]),
			.d_y (d_y[e]),
			.res (res[e])
		);
	end

	assign box_hit = res[0].hit || res[1].hit || res[2].hit || res[3].hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[LAT-2:0], s_axis_tvalid};
			out_vld_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_d[0] <= s_axis_tuser;
			p0x_d[0] <= p0_x;
			p0y_d[0] <= p0_y;
			for (int k = 1; k < EDGE_LAT; k++) begin
				cmd_d[k] <= cmd_d[k-1];
				p0x_d[k] <= p0x_d[k-1];
				p0y_d[k] <= p0y_d[k-1];
			end

			hit_s5   <= (cmd_d[EDGE_LAT-1] == CMD_BOX) ? box_hit : res[0].hit;
			seg_s5   <= (cmd_d[EDGE_LAT-1] == CMD_SEG);
			numx_s5  <= mag_sum(res[0].t) * mag_diff(res[0].rx);
			numy_s5  <= mag_sum(res[0].t) * mag_diff(res[0].ry);
			den_s5   <= mag_sum(res[0].d);
			negx_s5  <= (res[0].t < 0) ^ (res[0].d < 0) ^ (res[0].rx < 0);
			negy_s5  <= (res[0].t < 0) ^ (res[0].d < 0) ^ (res[0].ry < 0);
			basex_s5 <= p0x_d[EDGE_LAT-1];
			basey_s5 <= p0y_d[EDGE_LAT-1];

			hit_d[0] <= hit_s5;
			seg_d[0] <= seg_s5;
			for (int k = 1; k < DIV_LAT; k++) begin
				hit_d[k] <= hit_d[k-1];
				seg_d[k] <= seg_d[k-1];
			end

			hit_q <= hit_d[DIV_LAT-1];
			ptx_q <= (hit_d[DIV_LAT-1] && seg_d[DIV_LAT-1]) ? divx : '0;
			pty_q <= (hit_d[DIV_LAT-1] && seg_d[DIV_LAT-1]) ? divy : '0;
		end
	end

	sit_div u_div_x (
		.clk   (clk),
		.en    (en),
		.num   (numx_s5),
		.den   (den_s5),
		.neg   (negx_s5),
		.base  (basex_s5),
		.point (divx)
	);

	sit_div u_div_y (
		.clk   (clk),
		.en    (en),
		.num   (numy_s5),
		.den   (den_s5),
		.neg   (negy_s5),
		.base  (basey_s5),
		.point (divy)
	);

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'b0, pty_q, ptx_q, hit_q};

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_q[0])
		else $error("accepted query did not enter the pipeline");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(vld_q))
		else $error("pipeline moved during output stall");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !hit_q |-> (ptx_q == 0) && (pty_q == 0))
		else $error("miss reported with nonzero point");

endmodule

FILE: design/sit_edge.sv
// Four-stage cross-product test of one segment against one edge.
module sit_edge (
	input  logic              clk,
	input  logic              en,
	input  sit_pkg::ept_t     a_x,
	input  sit_pkg::ept_t     a_y,
	input  sit_pkg::ept_t     b_x,
	input  sit_pkg::ept_t     b_y,
	input  sit_pkg::ept_t     c_x,
	input  sit_pkg::ept_t     c_y,
	input  sit_pkg::ept_t     d_x,
	input  sit_pkg::ept_t     d_y,
	output sit_pkg::edge_res_t res
);
	import sit_pkg::*;

	diff_t rx_s1, ry_s1, sx_s1, sy_s1, wx_s1, wy_s1;
	prod_t pd1_s2, pd2_s2, pt1_s2, pt2_s2, pu1_s2, pu2_s2;
	diff_t rx_s2, ry_s2, rx_s3, ry_s3;
	sum_t  d_s3, t_s3, u_s3;
	edge_res_t res_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= DW'(b_x) - DW'(a_x);
			ry_s1 <= DW'(b_y) - DW'(a_y);
			sx_s1 <= DW'(d_x) - DW'(c_x);
			sy_s1 <= DW'(d_y) - DW'(c_y);
			wx_s1 <= DW'(c_x) - DW'(a_x);
			wy_s1 <= DW'(c_y) - DW'(a_y);

			pd1_s2 <= rx_s1 * sy_s1;
			pd2_s2 <= ry_s1 * sx_s1;
			pt1_s2 <= wx_s1 * sy_s1;
			pt2_s2 <= wy_s1 * sx_s1;
			pu1_s2 <= wx_s1 * ry_s1;
			pu2_s2 <= wy_s1 * rx_s1;
			rx_s2  <= rx_s1;
			ry_s2  <= ry_s1;

			d_s3  <= SW'(pd1_s2) - SW'(pd2_s2);
			t_s3  <= SW'(pt1_s2) - SW'(pt2_s2);
			u_s3  <= SW'(pu1_s2) - SW'(pu2_s2);
			rx_s3 <= rx_s2;
			ry_s3 <= ry_s2;

			// zero cross product is a miss, parallel or collinear
			res_s4.hit <= (d_s3 != 0) && in_unit(t_s3, d_s3) && in_unit(u_s3, d_s3);
			res_s4.t   <= t_s3;
			res_s4.d   <= d_s3;
			res_s4.rx  <= rx_s3;
			res_s4.ry  <= ry_s3;
		end
	end

	assign res = res_s4;

endmodule

FILE: design/sit_div.sv
// Radix-2 restoring divider, one quotient bit per stage, with signed offset.
module sit_div (
	input  logic                    clk,
	input  logic                    en,
	input  logic [sit_pkg::NW-1:0]  num,
	input  logic [sit_pkg::MW-1:0]  den,
	input  logic                    neg,
	input  sit_pkg::coord_t         base,
	output sit_pkg::coord_t         point
);
	import sit_pkg::*;

	logic [MW-1:0] rem_s  [QW];
	logic [QW-1:0] low_s  [QW];
	logic [MW-1:0] den_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic          neg_s  [QW];
	coord_t        base_s [QW];

	logic [MW-1:0] rem_in  [QW];
	logic [QW-1:0] low_in  [QW];
	logic [MW-1:0] den_in  [QW];
	logic [QW-1:0] quo_in  [QW];
	logic          neg_in  [QW];
	coord_t        base_in [QW];
	logic [MW:0]   trial   [QW];
	logic          take    [QW];
	logic [CW-1:0] qlo;

	always_comb begin
		rem_in[0]  = num[NW-1:QW];
		low_in[0]  = num[QW-1:0];
		den_in[0]  = den;
		quo_in[0]  = '0;
		neg_in[0]  = neg;
		base_in[0] = base;
		for (int k = 1; k < QW; k++) begin
			rem_in[k]  = rem_s[k-1];
			low_in[k]  = low_s[k-1];
			den_in[k]  = den_s[k-1];
			quo_in[k]  = quo_s[k-1];
			neg_in[k]  = neg_s[k-1];
			base_in[k] = base_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			trial[k] = {rem_in[k], low_in[k][QW-1]};
			take[k]  = trial[k] >= {1'b0, den_in[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k]  <= take[k] ? MW'(trial[k] - {1'b0, den_in[k]}) : trial[k][MW-1:0];
				quo_s[k]  <= {quo_in[k][QW-2:0], take[k]};
				low_s[k]  <= {low_in[k][QW-2:0], 1'b0};
				den_s[k]  <= den_in[k];
				neg_s[k]  <= neg_in[k];
				base_s[k] <= base_in[k];
			end
		end
	end

	// quotient truncates toward zero; the sum always fits the coordinate range
	assign qlo   = quo_s[QW-1][CW-1:0];
	assign point = base_s[QW-1] + coord_t'(neg_s[QW-1] ? -qlo : qlo);

endmodule
